/* sv/smih_pkg.sv */
package smih_pkg;

  localparam int unsigned BinCountDefault = 100;
  localparam int unsigned HistAddrW       = 8;
  localparam int unsigned CntW            = 40;
  localparam int unsigned DivW            = 40;
  localparam int unsigned ScaleW          = 39;
  localparam int unsigned LimitReset      = 5;
  localparam logic [6:0]  PercentScale    = 7'd100;

  typedef enum logic {
    CMD_COMPARE = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_LOW_COUNT_LIMIT = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SCALE,
    DIV_STEP
  } div_state_e;

  typedef struct packed {
    logic        command;
    logic [63:0] key_a;
    logic [31:0] count_a;
    logic [63:0] key_b;
    logic [31:0] count_b;
    logic [6:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic            advance_a;
    logic            advance_b;
    logic            matched;
    logic [6:0]      diff_bin;
    logic [CntW-1:0] bin_total;
    logic [CntW-1:0] bin_low_total;
    logic [CntW-1:0] match_total;
  } out_item_t;

  typedef struct packed {
    logic [HistAddrW-1:0] addr;
    logic                 rd_en;
    logic                 wr_diff_en;
    logic                 wr_low_en;
    logic [CntW-1:0]      wdata_diff;
    logic [CntW-1:0]      wdata_low;
  } hist_req_t;

  typedef struct packed {
    logic [CntW-1:0] diff;
    logic [CntW-1:0] low;
  } hist_rsp_t;

endpackage

/* sv/smih_divider.sv */
module smih_divider import smih_pkg::*; #(
  parameter int unsigned BIN_COUNT = BinCountDefault,
  parameter int unsigned AW        = $clog2(BIN_COUNT)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   lo_i,
  input  logic [31:0]   hi_i,
  output logic          done_o,
  output logic [AW-1:0] bin_o
);

  localparam logic [AW-1:0] Top = AW'(BIN_COUNT - 1);
  localparam int unsigned   CW  = $clog2(AW + 1);

  div_state_e       state_q, state_d;
  logic [31:0]      diff_q, lo_q;
  logic [DivW-1:0]  rem_q, sh_q;
  logic [AW-1:0]    quo_q, bin_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic             ge;
  logic [AW-1:0]    quo_next;
  logic [ScaleW-1:0] scaled;

  assign ge       = rem_q >= sh_q;
  assign quo_next = AW'({quo_q, ge});
  assign scaled   = ScaleW'(diff_q) * ScaleW'(PercentScale);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i && lo_i != 32'd0) begin
          state_d = DIV_SCALE;
        end
      end
      DIV_SCALE: state_d = DIV_STEP;
      DIV_STEP: begin
        if ((cnt_q == CW'(AW) && ge) || cnt_q == '0) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DIV_IDLE && start_i && lo_i == 32'd0) ||
                 (state_q == DIV_STEP && state_d == DIV_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIV_IDLE: begin
        diff_q <= hi_i - lo_i;
        lo_q   <= lo_i;
        if (start_i && lo_i == 32'd0) begin
          bin_q <= Top;
        end
      end
      DIV_SCALE: begin
        rem_q <= DivW'(scaled);
        sh_q  <= DivW'(lo_q) << AW;
        cnt_q <= CW'(AW);
        quo_q <= '0;
      end
      DIV_STEP: begin
        if (cnt_q == CW'(AW) && ge) begin
          bin_q <= Top;
        end else begin
          quo_q <= quo_next;
          rem_q <= ge ? rem_q - sh_q : rem_q;
          sh_q  <= sh_q >> 1;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            bin_q <= (quo_next > Top) ? Top : quo_next;
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign bin_o  = bin_q;

endmodule

/* sv/smih_hist.sv */
module smih_hist import smih_pkg::*; #(
  parameter int unsigned BIN_COUNT = BinCountDefault,
  parameter int unsigned AW        = $clog2(BIN_COUNT)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hist_req_t req_i,
  output hist_rsp_t rsp_o
);

  logic [CntW-1:0]      diff_mem [BIN_COUNT];
  logic [CntW-1:0]      low_mem  [BIN_COUNT];
  logic [BIN_COUNT-1:0] diff_vld_q, low_vld_q;
  logic [CntW-1:0]      diff_rd_q, low_rd_q;
  logic                 diff_rvld_q, low_rvld_q;
  logic [AW-1:0]        addr;

  assign addr = req_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_diff_en) begin
      diff_mem[addr] <= req_i.wdata_diff;
    end
    if (req_i.wr_low_en) begin
      low_mem[addr] <= req_i.wdata_low;
    end
    if (req_i.rd_en) begin
      diff_rd_q <= diff_mem[addr];
      low_rd_q  <= low_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_vld_q  <= '0;
      low_vld_q   <= '0;
      diff_rvld_q <= 1'b0;
      low_rvld_q  <= 1'b0;
    end else begin
      if (req_i.wr_diff_en) begin
        diff_vld_q[addr] <= 1'b1;
      end
      if (req_i.wr_low_en) begin
        low_vld_q[addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        diff_rvld_q <= diff_vld_q[addr];
        low_rvld_q  <= low_vld_q[addr];
      end
    end
  end

  assign rsp_o.diff = diff_rvld_q ? diff_rd_q : '0;
  assign rsp_o.low  = low_rvld_q  ? low_rd_q  : '0;

endmodule

/* sv/sorted_merge_intersect_histogram_unit.sv */
// Merge-join step over two sorted key/count lists with ratio histograms. One
// transaction is taken at a time; in_stall_o stays high until its result is
// loaded into the output register, which may still hold the previous result.
// A key mismatch goes straight to the output stage, a histogram read passes
// through a read and a read-wait state (skipped when out of range), and a match
// waits on the compare-subtract divider (one quotient bit per cycle),
// followed by a read-modify-write of both histogram memories. Histograms
// and the match counter are zero after reset with no clearing pass.
module sorted_merge_intersect_histogram_unit import smih_pkg::*; #(
  parameter int unsigned BIN_COUNT = BinCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(BIN_COUNT);

  state_e          state_q, state_d;
  in_item_t        in_q;
  out_item_t       res_q, res_d, out_q;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] match_cnt_q, match_cnt_d;
  logic [31:0]     limit_q, lo_q, lo_d;
  logic [AW-1:0]   bin_q, bin_d;
  logic            in_accept, out_load, div_start, div_done;
  logic [AW-1:0]   div_bin;
  logic [31:0]     lo, hi;
  logic            bin_in_range;
  hist_req_t       hist_req;
  hist_rsp_t       hist_rsp;

  assign in_accept    = in_valid_i && !in_stall_o;
  assign in_stall_o   = state_q != ST_IDLE;
  assign lo           = (in_q.count_a < in_q.count_b) ? in_q.count_a : in_q.count_b;
  assign hi           = (in_q.count_a < in_q.count_b) ? in_q.count_b : in_q.count_a;
  assign bin_in_range = {2'b00, in_q.bin_index} < 9'(BIN_COUNT);

  smih_divider #(.BIN_COUNT(BIN_COUNT), .AW(AW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .lo_i   (lo),
    .hi_i   (hi),
    .done_o (div_done),
    .bin_o  (div_bin)
  );

  smih_hist #(.BIN_COUNT(BIN_COUNT), .AW(AW)) u_hist (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (hist_req),
    .rsp_o (hist_rsp)
  );

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    lo_d        = lo_q;
    bin_d       = bin_q;
    match_cnt_d = match_cnt_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    hist_req    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_d = '0;
        if (in_q.command == CMD_READ) begin
          state_d = bin_in_range ? ST_RD : ST_DONE;
        end else if (in_q.key_a == in_q.key_b) begin
          res_d.advance_a = 1'b1;
          res_d.advance_b = 1'b1;
          res_d.matched   = 1'b1;
          lo_d            = lo;
          match_cnt_d     = match_cnt_q + CntW'(1);
          div_start       = 1'b1;
          state_d         = ST_DIV;
        end else if (in_q.key_a > in_q.key_b) begin
          res_d.advance_b = 1'b1;
          state_d         = ST_DONE;
        end else begin
          res_d.advance_a = 1'b1;
          state_d         = ST_DONE;
        end
        res_d.match_total = match_cnt_d;
      end
      ST_DIV: begin
        if (div_done) begin
          bin_d          = div_bin;
          res_d.diff_bin = 7'(div_bin);
          state_d        = ST_RMW_RD;
        end
      end
      ST_RMW_RD: begin
        hist_req.addr  = HistAddrW'(bin_q);
        hist_req.rd_en = 1'b1;
        state_d        = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        hist_req.addr       = HistAddrW'(bin_q);
        hist_req.wr_diff_en = 1'b1;
        hist_req.wr_low_en  = lo_q < limit_q;
        hist_req.wdata_diff = hist_rsp.diff + CntW'(1);
        hist_req.wdata_low  = hist_rsp.low + CntW'(1);
        state_d             = ST_DONE;
      end
      ST_RD: begin
        hist_req.addr  = HistAddrW'(in_q.bin_index);
        hist_req.rd_en = 1'b1;
        state_d        = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        res_d.bin_total     = hist_rsp.diff;
        res_d.bin_low_total = hist_rsp.low;
        state_d             = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      match_cnt_q <= '0;
      limit_q     <= 32'(LimitReset);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      match_cnt_q <= match_cnt_d;
      if (psel && penable && pwrite && paddr[2] == REG_LOW_COUNT_LIMIT) begin
        limit_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    res_q <= res_d;
    lo_q  <= lo_d;
    bin_q <= bin_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_LOW_COUNT_LIMIT) ? limit_q : 32'd0;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("unit not busy after accepting a transaction");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_req.wr_diff_en |-> {1'b0, hist_req.addr} < 9'(BIN_COUNT))
    else $error("histogram write outside bin range");

  a_low_implies_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_req.wr_low_en |-> hist_req.wr_diff_en)
    else $error("low histogram written without difference histogram");

  a_count_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_cnt_q != $past(match_cnt_q)) |-> ($past(state_q) == ST_EVAL && res_q.matched))
    else $error("match counter changed without a match");
`endif

endmodule
